@@ hw/rtl/bmpfb_pkg.sv @@
// Shared types and constants for the BMP row stream to framebuffer blit.
package bmpfb_pkg;

   localparam int COORD_BITS = 12;
   localparam int RBC_BITS   = COORD_BITS + 2;
   localparam int PITCH_BITS = 13;
   localparam int ADDR_BITS  = 25;
   localparam int PIXEL_BITS = 32;
   localparam int OFFS_BITS  = 20;
   localparam int LENS_BITS  = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_FIRST     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_PITCH    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHAN_OFFSETS  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHAN_LENGTHS  = 3'd7;

   // reset values
   localparam logic [COORD_BITS-1:0] RST_IMAGE_WIDTH   = 12'd1;
   localparam logic [COORD_BITS-1:0] RST_IMAGE_HEIGHT  = 12'd1;
   localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = 12'd800;
   localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = 12'd480;
   localparam logic [PITCH_BITS-1:0] RST_LINE_PITCH    = 13'd800;
   localparam logic [OFFS_BITS-1:0]  RST_CHAN_OFFSETS  = 20'd786704;
   localparam logic [LENS_BITS-1:0]  RST_CHAN_LENGTHS  = 16'd34952;

   // byte position within a pixel
   localparam logic [1:0] PH_BLUE  = 2'd0;
   localparam logic [1:0] PH_GREEN = 2'd1;
   localparam logic [1:0] PH_RED   = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] image_width;
      logic [COORD_BITS-1:0] image_height;
      logic                  top_first;
      logic [COORD_BITS-1:0] screen_width;
      logic [COORD_BITS-1:0] screen_height;
      logic [PITCH_BITS-1:0] line_pitch_words;
      logic [OFFS_BITS-1:0]  channel_offsets;
      logic [LENS_BITS-1:0]  channel_lengths;
   } cfg_type;

   // one on-screen pixel waiting for address and packing
   typedef struct packed {
      logic [COORD_BITS-1:0] dx;
      logic [COORD_BITS-1:0] dy;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
   } pix_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

@@ hw/rtl/bmpfb_front.sv @@
// Front end: byte gathering, row and padding tracking, clipping to the screen.
module bmpfb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  bmpfb_pkg::cfg_type      cfg,
   input  logic                    byte_accept,
   input  logic                    start_of_image,
   input  logic [7:0]              data_byte,
   output logic                    push,
   output bmpfb_pkg::pix_entry_type push_entry
);

   logic [1:0]                       phase_ff, phase_in;
   logic [bmpfb_pkg::COORD_BITS-1:0] col_ff, col_in;
   logic [bmpfb_pkg::COORD_BITS-1:0] row_ff, row_in;
   logic [bmpfb_pkg::RBC_BITS-1:0]   rbc_ff, rbc_in;
   logic [7:0]                       blue_ff, blue_in;
   logic [7:0]                       green_ff, green_in;

   logic [1:0]                       phase_eff;
   logic [bmpfb_pkg::COORD_BITS-1:0] col_eff, row_eff, row_sel, x0, y0;
   logic [bmpfb_pkg::RBC_BITS-1:0]   rbc_eff, rbc_next, pix_bytes, padded_len;
   logic [bmpfb_pkg::COORD_BITS:0]   dx, dy;
   logic                             active, in_pix, row_end, on_screen;

   always_comb begin
      // start of image clears the counters before the byte is taken
      phase_eff = start_of_image ? bmpfb_pkg::PH_BLUE : phase_ff;
      col_eff   = start_of_image ? '0 : col_ff;
      row_eff   = start_of_image ? '0 : row_ff;
      rbc_eff   = start_of_image ? '0 : rbc_ff;

      pix_bytes  = bmpfb_pkg::RBC_BITS'({cfg.image_width, 1'b0})
                 + bmpfb_pkg::RBC_BITS'(cfg.image_width);
      padded_len = (pix_bytes + bmpfb_pkg::RBC_BITS'(3)) & ~bmpfb_pkg::RBC_BITS'(3);

      if (cfg.screen_width > cfg.image_width) begin
         x0 = (cfg.screen_width - cfg.image_width) >> 1;
      end else begin
         x0 = '0;
      end
      if (cfg.screen_height > cfg.image_height) begin
         y0 = (cfg.screen_height - cfg.image_height) >> 1;
      end else begin
         y0 = '0;
      end

      active   = row_eff < cfg.image_height;
      in_pix   = rbc_eff < pix_bytes;
      rbc_next = rbc_eff + bmpfb_pkg::RBC_BITS'(1);
      row_end  = rbc_next >= padded_len;

      // only used when active, so the bottom-up flip cannot go negative
      row_sel   = cfg.top_first ? row_eff
                                : cfg.image_height - bmpfb_pkg::COORD_BITS'(1) - row_eff;
      dx        = (bmpfb_pkg::COORD_BITS+1)'(x0) + (bmpfb_pkg::COORD_BITS+1)'(col_eff);
      dy        = (bmpfb_pkg::COORD_BITS+1)'(y0) + (bmpfb_pkg::COORD_BITS+1)'(row_sel);
      on_screen = (dx < (bmpfb_pkg::COORD_BITS+1)'(cfg.screen_width))
               && (dy < (bmpfb_pkg::COORD_BITS+1)'(cfg.screen_height));

      phase_in = phase_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      rbc_in   = rbc_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      push     = 1'b0;

      if (byte_accept) begin
         phase_in = phase_eff;
         col_in   = col_eff;
         row_in   = row_eff;
         rbc_in   = rbc_eff;
         if (active) begin
            if (in_pix) begin
               case (phase_eff)
                  bmpfb_pkg::PH_BLUE: begin
                     blue_in  = data_byte;
                     phase_in = bmpfb_pkg::PH_GREEN;
                  end
                  bmpfb_pkg::PH_GREEN: begin
                     green_in = data_byte;
                     phase_in = bmpfb_pkg::PH_RED;
                  end
                  default: begin
                     push     = on_screen;
                     col_in   = col_eff + bmpfb_pkg::COORD_BITS'(1);
                     phase_in = bmpfb_pkg::PH_BLUE;
                  end
               endcase
            end
            rbc_in = rbc_next;
            if (row_end) begin
               rbc_in   = '0;
               col_in   = '0;
               phase_in = bmpfb_pkg::PH_BLUE;
               row_in   = row_eff + bmpfb_pkg::COORD_BITS'(1);
            end
         end
      end

      push_entry.dx    = dx[bmpfb_pkg::COORD_BITS-1:0];
      push_entry.dy    = dy[bmpfb_pkg::COORD_BITS-1:0];
      push_entry.red   = data_byte;
      push_entry.green = green_ff;
      push_entry.blue  = blue_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bmpfb_pkg::PH_BLUE;
         col_ff   <= '0;
         row_ff   <= '0;
         rbc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         rbc_ff   <= rbc_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

endmodule

@@ hw/rtl/bmpfb_queue.sv @@
// Short pixel queue between the front end and the packing back end.
module bmpfb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bmpfb_pkg::pix_entry_type push_entry,
   input  logic                     pop,
   output bmpfb_pkg::pix_entry_type head,
   output bmpfb_pkg::q_status_type  status
);

   bmpfb_pkg::pix_entry_type        slot_ff [bmpfb_pkg::QUEUE_DEPTH];
   logic [bmpfb_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bmpfb_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bmpfb_pkg::QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      status.full      = count_ff == bmpfb_pkg::QCNT_BITS'(bmpfb_pkg::QUEUE_DEPTH);
      status.not_empty = count_ff != '0;
      head             = slot_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + bmpfb_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bmpfb_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bmpfb_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bmpfb_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/bmpfb_back.sv @@
// Back end: framebuffer word index and channel packing into the output register.
module bmpfb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  bmpfb_pkg::cfg_type                cfg,
   input  bmpfb_pkg::pix_entry_type          head,
   input  bmpfb_pkg::q_status_type           q_status,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [bmpfb_pkg::ADDR_BITS-1:0]   out_address,
   output logic [bmpfb_pkg::PIXEL_BITS-1:0]  out_pixel
);

   logic                             valid_ff, valid_in;
   logic [bmpfb_pkg::ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [bmpfb_pkg::PIXEL_BITS-1:0] pixel_ff, pixel_in;

   // length saturates at eight; a zero length adds nothing
   function automatic logic [bmpfb_pkg::PIXEL_BITS-1:0] put_channel(
      input logic [7:0] value,
      input logic [3:0] len,
      input logic [4:0] off
   );
      logic [3:0]                       len_sat;
      logic [bmpfb_pkg::PIXEL_BITS-1:0] field;
      len_sat = (len > 4'd8) ? 4'd8 : len;
      field   = bmpfb_pkg::PIXEL_BITS'(value >> (4'd8 - len_sat));
      if (len_sat == 4'd0) begin
         return '0;
      end
      return field << off;
   endfunction

   always_comb begin
      pop = q_status.not_empty && (!valid_ff || out_ready);

      valid_in = valid_ff;
      addr_in  = addr_ff;
      pixel_in = pixel_ff;
      if (pop) begin
         valid_in = 1'b1;
         addr_in  = bmpfb_pkg::ADDR_BITS'(head.dy) * bmpfb_pkg::ADDR_BITS'(cfg.line_pitch_words)
                  + bmpfb_pkg::ADDR_BITS'(head.dx);
         pixel_in = put_channel(head.red,   cfg.channel_lengths[3:0],   cfg.channel_offsets[4:0])
                  | put_channel(head.green, cfg.channel_lengths[7:4],   cfg.channel_offsets[9:5])
                  | put_channel(head.blue,  cfg.channel_lengths[11:8],  cfg.channel_offsets[14:10])
                  | put_channel(8'hff,      cfg.channel_lengths[15:12], cfg.channel_offsets[19:15]);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      pixel_ff <= pixel_in;
   end

   assign out_valid   = valid_ff;
   assign out_address = addr_ff;
   assign out_pixel   = pixel_ff;

endmodule

@@ hw/rtl/bmp_row_stream_to_framebuffer_blit.sv @@
// Top level: register file, front end, pixel queue and packing back end.
//
// Input words carry one BMP pixel byte (blue, green, red order, rows padded to
// four bytes); req_tuser marks the first byte of an image and clears the
// position counters. Each complete pixel that lands on the screen comes out as
// one rsp word with its framebuffer word index and packed 32-bit value;
// padding bytes, off-screen pixels and bytes after the last row give nothing.
// The block takes one byte per clock while the queue is not full. A kept pixel
// passes from the queue, which takes it when its red byte is accepted, to the
// back end multiply-add and packing register that drives rsp_tvalid.
// A four-entry queue sits between the front and back ends. When rsp_tready is
// held low the queue fills and req_tready drops once it is full; nothing is
// lost. Reset clears the counters, the queue and the output register and
// loads the default screen geometry and channel layout. The csr channel is
// always ready and should only be written while no pixel is in flight.
module bmp_row_stream_to_framebuffer_blit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // data_byte[7:0]
   input  logic                                 req_tuser,  // start_of_image
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [63:0]                          rsp_tdata,  // word_address[24:0],
                                                            // pixel_word[56:25]
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmpfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bmpfb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   bmpfb_pkg::cfg_type               cfg_ff, cfg_in;
   bmpfb_pkg::pix_entry_type         push_entry, head;
   bmpfb_pkg::q_status_type          q_status;
   logic                             push, pop, byte_accept;
   logic [bmpfb_pkg::ADDR_BITS-1:0]  out_address;
   logic [bmpfb_pkg::PIXEL_BITS-1:0] out_pixel;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bmpfb_pkg::REG_IMAGE_WIDTH:   cfg_in.image_width      = csr_wdata[11:0];
            bmpfb_pkg::REG_IMAGE_HEIGHT:  cfg_in.image_height     = csr_wdata[11:0];
            bmpfb_pkg::REG_TOP_FIRST:     cfg_in.top_first        = csr_wdata[0];
            bmpfb_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width     = csr_wdata[11:0];
            bmpfb_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height    = csr_wdata[11:0];
            bmpfb_pkg::REG_LINE_PITCH:    cfg_in.line_pitch_words = csr_wdata[12:0];
            bmpfb_pkg::REG_CHAN_OFFSETS:  cfg_in.channel_offsets  = csr_wdata[19:0];
            bmpfb_pkg::REG_CHAN_LENGTHS:  cfg_in.channel_lengths  = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= bmpfb_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height     <= bmpfb_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.top_first        <= 1'b0;
         cfg_ff.screen_width     <= bmpfb_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height    <= bmpfb_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.line_pitch_words <= bmpfb_pkg::RST_LINE_PITCH;
         cfg_ff.channel_offsets  <= bmpfb_pkg::RST_CHAN_OFFSETS;
         cfg_ff.channel_lengths  <= bmpfb_pkg::RST_CHAN_LENGTHS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready  = !q_status.full;
   assign byte_accept = req_tvalid && req_tready;

   bmpfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .byte_accept    (byte_accept),
      .start_of_image (req_tuser),
      .data_byte      (req_tdata),
      .push           (push),
      .push_entry     (push_entry)
   );

   bmpfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   bmpfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_address (out_address),
      .out_pixel   (out_pixel)
   );

   assign rsp_tdata = {7'b0, out_pixel, out_address};

endmodule

@@ tb/tb_bmp_row_stream_to_framebuffer_blit.sv @@
// Self-checking testbench for the BMP row stream to framebuffer blit.
module tb_bmp_row_stream_to_framebuffer_blit;
   timeunit 1ns;
   timeprecision 1ps;
   import bmpfb_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_TARGET   = 1600;

   typedef struct packed {
      logic       sof;
      logic [7:0] data;
   } pixel_byte_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] pixel;
   } fb_write_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;  // data_byte[7:0]
   logic                      req_tuser = 1'b0;  // start_of_image
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [63:0]               rsp_tdata;  // word_address[24:0], pixel_word[56:25]
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   bmp_row_stream_to_framebuffer_blit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the block: register file and position counters
   cfg_type               blit_cfg;
   logic [1:0]            byte_slot;
   logic [COORD_BITS-1:0] col_pos;
   logic [COORD_BITS-1:0] row_pos;
   logic [RBC_BITS-1:0]   row_byte_pos;
   logic [7:0]            held_blue;
   logic [7:0]            held_green;

   pixel_byte_type pending_bytes[$];
   fb_write_type   fb_writes_due[$];

   logic [CSR_INDEX_BITS-1:0] reg_order [0:7] = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
      REG_TOP_FIRST, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_LINE_PITCH,
      REG_CHAN_OFFSETS, REG_CHAN_LENGTHS};

   logic        req_idle_on = 1'b0;
   logic        rsp_idle_on = 1'b0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          failures = 0;
   int          words_checked = 0;
   int          bytes_taken = 0;
   int          bytes_queued = 0;
   int          settings = 0;
   int unsigned cycle_count = 0;

   function automatic int idle_length(input logic enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] place_channel(input logic [7:0] value,
                                                 input logic [3:0] len,
                                                 input logic [4:0] offs);
      logic [3:0]  l;
      logic [31:0] v;
      l = (len > 4'd8) ? 4'd8 : len;
      if (l == 4'd0) return '0;
      v = {24'd0, value} >> (4'd8 - l);
      return v << offs;
   endfunction

   function automatic logic [31:0] pack_rgb(input logic [7:0] red, input logic [7:0] green,
                                            input logic [7:0] blue);
      return place_channel(red, blit_cfg.channel_lengths[3:0], blit_cfg.channel_offsets[4:0])
         | place_channel(green, blit_cfg.channel_lengths[7:4], blit_cfg.channel_offsets[9:5])
         | place_channel(blue, blit_cfg.channel_lengths[11:8], blit_cfg.channel_offsets[14:10])
         | place_channel(8'hff, blit_cfg.channel_lengths[15:12],
                         blit_cfg.channel_offsets[19:15]);
   endfunction

   task automatic reset_model();
      blit_cfg.image_width      = RST_IMAGE_WIDTH;
      blit_cfg.image_height     = RST_IMAGE_HEIGHT;
      blit_cfg.top_first        = 1'b0;
      blit_cfg.screen_width     = RST_SCREEN_WIDTH;
      blit_cfg.screen_height    = RST_SCREEN_HEIGHT;
      blit_cfg.line_pitch_words = RST_LINE_PITCH;
      blit_cfg.channel_offsets  = RST_CHAN_OFFSETS;
      blit_cfg.channel_lengths  = RST_CHAN_LENGTHS;
      byte_slot    = PH_BLUE;
      col_pos      = '0;
      row_pos      = '0;
      row_byte_pos = '0;
      held_blue    = '0;
      held_green   = '0;
   endtask

   // one accepted byte: advance the counters, queue the framebuffer write if on screen
   task automatic blit_byte(input logic sof, input logic [7:0] data);
      int unsigned  pix_bytes, padded_len, x0, y0, dx, dy;
      fb_write_type wr;
      pix_bytes  = blit_cfg.image_width * 3;
      padded_len = (pix_bytes + 3) / 4 * 4;
      if (sof) begin
         byte_slot    = PH_BLUE;
         col_pos      = '0;
         row_pos      = '0;
         row_byte_pos = '0;
      end
      if (row_pos >= blit_cfg.image_height) return;
      if (row_byte_pos < pix_bytes) begin
         case (byte_slot)
            PH_BLUE: begin
               held_blue = data;
               byte_slot = PH_GREEN;
            end
            PH_GREEN: begin
               held_green = data;
               byte_slot  = PH_RED;
            end
            default: begin
               x0 = (blit_cfg.screen_width > blit_cfg.image_width) ?
                    (blit_cfg.screen_width - blit_cfg.image_width) / 2 : 0;
               y0 = (blit_cfg.screen_height > blit_cfg.image_height) ?
                    (blit_cfg.screen_height - blit_cfg.image_height) / 2 : 0;
               dx = x0 + col_pos;
               // bottom-up files store the last screen row first
               dy = y0 + (blit_cfg.top_first ? row_pos : blit_cfg.image_height - 1 - row_pos);
               if (dx < blit_cfg.screen_width && dy < blit_cfg.screen_height) begin
                  wr.addr  = ADDR_BITS'(dy * blit_cfg.line_pitch_words + dx);
                  wr.pixel = pack_rgb(data, held_green, held_blue);
                  fb_writes_due.push_back(wr);
               end
               col_pos   = col_pos + 1'b1;
               byte_slot = PH_BLUE;
            end
         endcase
      end
      row_byte_pos = row_byte_pos + 1'b1;
      if (row_byte_pos >= padded_len) begin
         row_byte_pos = '0;
         col_pos      = '0;
         byte_slot    = PH_BLUE;
         row_pos      = row_pos + 1'b1;
      end
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_reg_value(
         input logic [CSR_INDEX_BITS-1:0] idx);
      int r;
      r = $urandom_range(0, 99);
      case (idx)
         REG_IMAGE_WIDTH:
            return CSR_DATA_BITS'((r < 6) ? 0 : (r < 12) ? 4095 : $urandom_range(1, 10));
         REG_IMAGE_HEIGHT:
            return CSR_DATA_BITS'((r < 6) ? 0 : (r < 12) ? 4095 : $urandom_range(1, 6));
         REG_TOP_FIRST:
            return CSR_DATA_BITS'($urandom_range(0, 1));
         REG_SCREEN_WIDTH:
            return CSR_DATA_BITS'((r < 10) ? 4095 : (r < 20) ? 1 : $urandom_range(1, 24));
         REG_SCREEN_HEIGHT:
            return CSR_DATA_BITS'((r < 10) ? 4095 : (r < 20) ? 1 : $urandom_range(1, 16));
         REG_LINE_PITCH:
            return CSR_DATA_BITS'((r < 10) ? 8191 : (r < 20) ? 1 : $urandom_range(1, 64));
         REG_CHAN_OFFSETS:
            return (r < 20) ? RST_CHAN_OFFSETS : OFFS_BITS'($urandom);
         default:
            return CSR_DATA_BITS'((r < 20) ? RST_CHAN_LENGTHS : LENS_BITS'($urandom));
      endcase
   endfunction

   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:   blit_cfg.image_width      = value[COORD_BITS-1:0];
         REG_IMAGE_HEIGHT:  blit_cfg.image_height     = value[COORD_BITS-1:0];
         REG_TOP_FIRST:     blit_cfg.top_first        = value[0];
         REG_SCREEN_WIDTH:  blit_cfg.screen_width     = value[COORD_BITS-1:0];
         REG_SCREEN_HEIGHT: blit_cfg.screen_height    = value[COORD_BITS-1:0];
         REG_LINE_PITCH:    blit_cfg.line_pitch_words = value[PITCH_BITS-1:0];
         REG_CHAN_OFFSETS:  blit_cfg.channel_offsets  = value[OFFS_BITS-1:0];
         default:           blit_cfg.channel_lengths  = value[LENS_BITS-1:0];
      endcase
   endtask

   function automatic void queue_byte(input logic sof, input logic [7:0] data);
      pixel_byte_type item;
      item.sof  = sof;
      item.data = data;
      pending_bytes.push_back(item);
      bytes_queued++;
   endfunction

   // n random bytes; first_sof on the first, then start-of-image one in sof_odds if non-zero
   task automatic queue_bytes(input int n, input logic first_sof, input int sof_odds);
      for (int i = 0; i < n; i++)
         queue_byte((i == 0) ? first_sof : (sof_odds > 0 && $urandom_range(1, sof_odds) == 1),
                    8'($urandom_range(0, 255)));
   endtask

   // all sent, every word back, then let the pipeline run dry
   task automatic wait_idle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || fb_writes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : req_driver
      pixel_byte_type item;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            blit_byte(req_tuser, req_tdata);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= item.sof;
               req_tdata  <= item.data;
               req_gap = idle_length(req_idle_on);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      fb_write_type due;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (fb_writes_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, got addr %h pixel %h", $time,
                        rsp_tdata[ADDR_BITS-1:0], rsp_tdata[ADDR_BITS +: PIXEL_BITS]);
               failures++;
            end else begin
               due = fb_writes_due.pop_front();
               if (rsp_tdata[ADDR_BITS-1:0] !== due.addr) begin
                  $display("%0t: word_address expected %h got %h", $time, due.addr,
                           rsp_tdata[ADDR_BITS-1:0]);
                  failures++;
               end
               if (rsp_tdata[ADDR_BITS +: PIXEL_BITS] !== due.pixel) begin
                  $display("%0t: pixel_word expected %h got %h", $time, due.pixel,
                           rsp_tdata[ADDR_BITS +: PIXEL_BITS]);
                  failures++;
               end
               words_checked++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = idle_length(rsp_idle_on);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, fb_writes_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int   rb, total, mode;
      logic lead_sof;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset layout: one 1x1 image, then a byte after the last row
      @(negedge clock);
      queue_byte(1'b1, 8'hff);
      queue_byte(1'b0, 8'h00);
      queue_byte(1'b0, 8'hff);
      queue_byte(1'b0, 8'h5a);
      queue_byte(1'b0, 8'h00);
      wait_idle();

      // 2x2 bottom-up on a one-column screen, clipped right, odd channel layout
      set_reg(REG_IMAGE_WIDTH, CSR_DATA_BITS'(2));
      set_reg(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      set_reg(REG_TOP_FIRST, CSR_DATA_BITS'(0));
      set_reg(REG_SCREEN_WIDTH, CSR_DATA_BITS'(1));
      set_reg(REG_SCREEN_HEIGHT, CSR_DATA_BITS'(4095));
      set_reg(REG_LINE_PITCH, CSR_DATA_BITS'(8191));
      set_reg(REG_CHAN_OFFSETS, {5'd27, 5'd0, 5'd5, 5'd31});
      set_reg(REG_CHAN_LENGTHS, CSR_DATA_BITS'({4'd8, 4'd15, 4'd0, 4'd9}));
      settings++;
      @(negedge clock);
      queue_byte(1'b1, 8'h00);
      queue_byte(1'b0, 8'hff);
      queue_byte(1'b0, 8'h80);
      queue_byte(1'b0, 8'h7f);
      queue_byte(1'b0, 8'hff);
      queue_byte(1'b0, 8'h00);
      queue_byte(1'b0, 8'hc3);
      queue_byte(1'b0, 8'h3c);
      queue_byte(1'b0, 8'h01);
      queue_byte(1'b0, 8'hfe);
      wait_idle();
      // change orientation and screen part way through the second row, inside its first pixel
      set_reg(REG_TOP_FIRST, CSR_DATA_BITS'(1));
      set_reg(REG_SCREEN_WIDTH, CSR_DATA_BITS'(4095));
      settings++;
      @(negedge clock);
      queue_byte(1'b0, 8'h55);
      queue_byte(1'b0, 8'haa);
      queue_byte(1'b0, 8'hff);
      queue_byte(1'b0, 8'h00);
      queue_byte(1'b0, 8'h5a);
      queue_byte(1'b0, 8'ha5);
      wait_idle();

      // zero width: each byte closes a row until the image height is reached
      set_reg(REG_IMAGE_WIDTH, CSR_DATA_BITS'(0));
      settings++;
      @(negedge clock);
      queue_byte(1'b1, 8'h12);
      queue_byte(1'b0, 8'h34);
      queue_byte(1'b0, 8'h56);
      wait_idle();

      // zero height: everything ignored
      set_reg(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(0));
      settings++;
      @(negedge clock);
      queue_byte(1'b1, 8'hff);

      while (bytes_queued < ITEM_TARGET) begin
         wait_idle();
         foreach (reg_order[i])
            if ($urandom_range(0, 1)) set_reg(reg_order[i], pick_reg_value(reg_order[i]));
         settings++;
         req_idle_on = ($urandom_range(0, 5) != 0);
         rsp_idle_on = ($urandom_range(0, 5) != 0);
         @(negedge clock);
         rb       = (int'(blit_cfg.image_width) * 3 + 3) / 4 * 4;
         total    = rb * int'(blit_cfg.image_height);
         lead_sof = ($urandom_range(0, 4) != 0);
         mode     = $urandom_range(0, 99);
         if (blit_cfg.image_width == 0 || blit_cfg.image_height == 0) begin
            queue_bytes($urandom_range(4, 12), 1'b1, 0);
         end else if (mode < 75 && total <= 200) begin
            queue_bytes(total, lead_sof, 0);
            if ($urandom_range(0, 1)) queue_bytes(total, 1'b1, 0);
            queue_bytes($urandom_range(0, 2), 1'b0, 0);
         end else if (mode < 90 || total > 200) begin
            // cut-off image, left unfinished for the next setting or restarted here
            queue_bytes((total > 200) ? $urandom_range(30, 120) : $urandom_range(1, total - 1),
                        lead_sof, 0);
            if (total <= 200) queue_bytes(total, 1'b1, 0);
         end else begin
            queue_bytes($urandom_range(20, 60), lead_sof, 8);
         end
      end

      wait_idle();
      $display("%0d bytes taken over %0d register settings, %0d framebuffer words checked",
               bytes_taken, settings, words_checked);
      $display("%0d mismatches seen", failures);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
